@@ src/iaf_pkg.sv @@
// ----------------------------------------------------------------------------
// iaf_pkg
// shared types, format codes and character constants of the integer to
// ascii formatter
// ----------------------------------------------------------------------------
package iaf_pkg;

    localparam int VALUE_W   = 32;
    localparam int FMT_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int DEC_DIGITS = 10;
    localparam int DIG_W     = 4 * DEC_DIGITS;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;

    localparam logic [FMT_W-1:0] FMT_SIGNED   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_UNSIGNED = 2'd1;
    localparam logic [FMT_W-1:0] FMT_HEX      = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A_LOW = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

    localparam logic [IDX_W-1:0] HEX_TOP_IDX  = 4'd7;
    localparam logic [CNT_W-1:0] CONV_STEPS_M1 = 5'd31;

    typedef struct packed {
        logic               neg;
        logic               hex;
        logic [VALUE_W-1:0] mag;
    } t_req;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d > 4'd9) begin
            c = CH_A_LOW + {4'b0, d} - 8'd10;
        end else begin
            c = CH_ZERO + {4'b0, d};
        end
        return c;
    endfunction

endpackage

@@ src/iaf_front.sv @@
// ----------------------------------------------------------------------------
// iaf_front
// accepts input requests, classifies the format and takes the magnitude
// ----------------------------------------------------------------------------
module iaf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [iaf_pkg::FMT_W-1:0] i_format,
    input  logic [iaf_pkg::VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_q_ready,
    output iaf_pkg::t_req             o_req
);
    import iaf_pkg::*;

    logic r_valid;
    t_req r_req;
    t_req n_req;

    always_comb begin
        n_req.hex = (i_format == FMT_HEX);
        n_req.neg = (i_format == FMT_SIGNED) && i_value[VALUE_W-1];
        n_req.mag = n_req.neg ? (~i_value + 32'd1) : i_value;
    end

    assign o_ready = !r_valid || i_q_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_req <= n_req;
        end
    end

endmodule

@@ src/iaf_queue.sv @@
// ----------------------------------------------------------------------------
// iaf_queue
// two-entry request queue between the front and back parts
// ----------------------------------------------------------------------------
module iaf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  iaf_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output iaf_pkg::t_req o_req
);
    import iaf_pkg::*;

    t_req       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

endmodule

@@ src/iaf_back.sv @@
// ----------------------------------------------------------------------------
// iaf_back
// converts one request to digits (shift-add-3 if decimal) and emits characters
// ----------------------------------------------------------------------------
module iaf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_ready,
    input  iaf_pkg::t_req              i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [iaf_pkg::CHAR_W-1:0] o_char,
    output logic                       o_last
);
    import iaf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic                r_neg;
    logic [VALUE_W-1:0]  r_bin;
    logic [DIG_W-1:0]    r_dig;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic [DIG_W-1:0]    n_dig;
    logic [IDX_W-1:0]    msd_idx;
    logic [3:0]          cur_digit;
    logic                out_free;
    logic                emit_go;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            n_dig[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? (r_dig[4*i +: 4] + 4'd3)
                                                          : r_dig[4*i +: 4];
        end
    end

    always_comb begin
        msd_idx = '0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_dig[4*i +: 4] != 4'd0) begin
                msd_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = r_dig[{r_idx, 2'b00} +: 4];
    assign out_free  = !r_out_valid || i_ready;
    assign emit_go   = ((r_state == ST_SIGN) || (r_state == ST_EMIT)) && out_free;
    assign o_q_ready = (r_state == ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_char    = r_char;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_neg <= i_req.neg;
                        if (i_req.hex) begin
                            r_dig   <= {8'b0, i_req.mag};
                            r_idx   <= HEX_TOP_IDX;
                            r_state <= ST_EMIT;
                        end else begin
                            r_bin   <= i_req.mag;
                            r_dig   <= '0;
                            r_cnt   <= CONV_STEPS_M1;
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    r_dig <= {n_dig[DIG_W-2:0], r_bin[VALUE_W-1]};
                    r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_idx   <= msd_idx;
                    r_state <= r_neg ? ST_SIGN : ST_EMIT;
                end
                ST_SIGN: begin
                    if (out_free) begin
                        r_char      <= CH_MINUS;
                        r_last      <= 1'b0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_char      <= digit_char(cur_digit);
                        r_last      <= (r_idx == '0);
                        r_idx       <= r_idx - 4'd1;
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/integer_to_ascii_formatter_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// formats a 32-bit value as signed decimal, unsigned decimal or hex text
// ----------------------------------------------------------------------------
// input stream: tdata carries the 32-bit value, tuser the format code
// (0 signed decimal, 1 unsigned decimal, 2 hex padded to eight digits,
// 3 handled as unsigned decimal). output stream: one ascii character per
// transfer in tdata, most significant first, tlast on the final character.
// the front stage registers and classifies each request and negates
// negative signed values; a two-entry queue decouples it from the back.
// the back converts decimal values with 32 shift-add-3 steps, one per cycle,
// then emits up to 11 characters, one per cycle while the receiver is ready.
// reset empties the queue, clears the front and output valid flags and idles the back.
// when the receiver stalls the output register holds, the back waits and
// the queue and front stage fill up before the input tready drops.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] format
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] character
    output logic        o_m_axis_tlast
);
    import iaf_pkg::*;

    logic front_valid;
    logic q_in_ready;
    t_req front_req;
    logic q_valid;
    logic back_ready;
    t_req q_req;

    iaf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_format  (i_s_axis_tuser),
        .i_value   (i_s_axis_tdata),
        .o_valid   (front_valid),
        .i_q_ready (q_in_ready),
        .o_req     (front_req)
    );

    iaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (q_in_ready),
        .i_req   (front_req),
        .o_valid (q_valid),
        .i_ready (back_ready),
        .o_req   (q_req)
    );

    iaf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (back_ready),
        .i_req     (q_req),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_char    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata >= CH_ZERO) && (o_m_axis_tdata <= 8'h39)) ||
            ((o_m_axis_tdata >= CH_A_LOW) && (o_m_axis_tdata <= 8'h66)) ||
            (o_m_axis_tdata == CH_MINUS))
        else $error("illegal output character");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata == CH_MINUS)) |-> !o_m_axis_tlast)
        else $error("minus sign flagged as last");

    a_hex_not_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> !(q_req.hex && q_req.neg))
        else $error("hex request classified as negative");

    a_neg_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && front_req.neg) |-> (front_req.mag != 32'd0))
        else $error("negative request with zero magnitude");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the integer to ascii formatter: a directed set of
// boundary values in every format, then randomly sized values under four
// sender and receiver idling mixes; every character and tlast is compared
// against a text predictor fed from each accepted request
// ----------------------------------------------------------------------------
module tb_top;
    import iaf_pkg::*;

    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

    typedef struct packed {
        logic [FMT_W-1:0]   fmt;
        logic [VALUE_W-1:0] value;
    } t_num_req;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [31:0]       i_s_axis_tdata = '0;   // [31:0] value
    logic [1:0]        i_s_axis_tuser = '0;   // [1:0] format
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [7:0]        o_m_axis_tdata;        // [7:0] character
    logic              o_m_axis_tlast;

    t_num_req   num_pending_q[$];
    t_text_char text_expect_q[$];
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         n_queued = 0;
    int         n_accepted = 0;
    int         n_chars = 0;
    int         n_per_fmt[4] = '{0, 0, 0, 0};
    int         err_cnt = 0;
    logic       req_taken = 1'b0;

    integer_to_ascii_formatter_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // expected text of one number, most significant character first
    function automatic void predict_text(input logic [FMT_W-1:0] fmt,
                                         input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [3:0]         dig [0:10];
        logic [CHAR_W-1:0]  ch;
        int                 nd;
        mag = value;
        nd = 0;
        radix = (fmt == FMT_HEX) ? 32'd16 : 32'd10;
        if (fmt == FMT_SIGNED && value[VALUE_W-1]) begin
            mag = ~value + 32'd1;
            text_expect_q.push_back('{ch: CH_MINUS, last: 1'b0});
        end
        do begin
            dig[nd] = 4'(mag % radix);
            nd++;
            mag = mag / radix;
        end while (mag != 0 && nd < 11);
        if (fmt == FMT_HEX) begin
            while (nd < 8) begin
                dig[nd] = 4'd0;
                nd++;
            end
        end
        for (int i = nd - 1; i >= 0; i--) begin
            ch = (dig[i] > 4'd9) ? CH_A_LOW + CHAR_W'(dig[i]) - 8'd10
                                 : CH_ZERO + CHAR_W'(dig[i]);
            text_expect_q.push_back('{ch: ch, last: (i == 0)});
        end
    endfunction

    task automatic queue_num(input logic [FMT_W-1:0] fmt, input logic [VALUE_W-1:0] value);
        num_pending_q.push_back('{fmt: fmt, value: value});
        n_queued++;
    endtask

    task automatic queue_random_nums(input int count);
        logic [FMT_W-1:0]   fmt;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] p10;
        repeat (count) begin
            fmt = ($urandom_range(99) < 8) ? FMT_SPARE : FMT_W'($urandom_range(2));
            case ($urandom_range(3))
                0: value = $urandom;
                1: value = $urandom >> $urandom_range(31);
                2: value = ~($urandom >> $urandom_range(31)) + 32'd1;
                default: begin
                    // around a power of ten, digit count boundaries
                    p10 = 32'd1;
                    repeat ($urandom_range(9)) p10 = p10 * 32'd10;
                    value = p10 - 32'd1 + $urandom_range(2);
                    if ($urandom_range(1)) value = ~value + 32'd1;
                end
            endcase
            queue_num(fmt, value);
        end
    endtask

    task automatic drain_all;
        while (n_accepted != n_queued || text_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // request driver and receiver backpressure
    always @(negedge i_clk) begin : drive
        t_num_req req;
        if (i_rst_n) begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if (!i_s_axis_tvalid || req_taken) begin
                if (num_pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    req = num_pending_q.pop_front();
                    i_s_axis_tdata  <= req.value;
                    i_s_axis_tuser  <= req.fmt;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // accepted requests feed the predictor, accepted characters are checked
    always @(posedge i_clk) begin : watch
        t_text_char exp_c;
        if (i_rst_n) begin
            req_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_text(i_s_axis_tuser, i_s_axis_tdata);
                n_accepted++;
                n_per_fmt[i_s_axis_tuser]++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_chars++;
                if (text_expect_q.size() == 0) begin
                    $error("unexpected character 0x%02h last %0b", o_m_axis_tdata,
                           o_m_axis_tlast);
                    err_cnt++;
                end else begin
                    exp_c = text_expect_q.pop_front();
                    if (o_m_axis_tdata !== exp_c.ch) begin
                        $error("character: expected 0x%02h actual 0x%02h", exp_c.ch,
                               o_m_axis_tdata);
                        err_cnt++;
                    end
                    if (o_m_axis_tlast !== exp_c.last) begin
                        $error("last: expected %0b actual %0b", exp_c.last, o_m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed boundaries, no idling
        queue_num(FMT_SIGNED, 32'h0000_0000);
        queue_num(FMT_SIGNED, 32'h0000_0001);
        queue_num(FMT_SIGNED, 32'hffff_ffff);
        queue_num(FMT_SIGNED, 32'h7fff_ffff);
        queue_num(FMT_SIGNED, 32'h8000_0000);
        queue_num(FMT_SIGNED, 32'h8000_0001);
        queue_num(FMT_SIGNED, 32'hc465_3600);
        queue_num(FMT_UNSIGNED, 32'h0000_0000);
        queue_num(FMT_UNSIGNED, 32'h0000_0009);
        queue_num(FMT_UNSIGNED, 32'h0000_000a);
        queue_num(FMT_UNSIGNED, 32'd1000000000);
        queue_num(FMT_UNSIGNED, 32'hffff_ffff);
        queue_num(FMT_UNSIGNED, 32'h8000_0000);
        queue_num(FMT_HEX, 32'h0000_0000);
        queue_num(FMT_HEX, 32'h0000_000a);
        queue_num(FMT_HEX, 32'hffff_ffff);
        queue_num(FMT_HEX, 32'hdead_beef);
        queue_num(FMT_HEX, 32'h1234_5678);
        queue_num(FMT_SPARE, 32'h0000_0000);
        queue_num(FMT_SPARE, 32'h0000_007b);
        queue_num(FMT_SPARE, 32'hffff_ffff);
        queue_random_nums(90);
        drain_all();

        gap_pct = 47;
        stall_pct = 0;
        queue_random_nums(105);
        drain_all();

        gap_pct = 0;
        stall_pct = 47;
        queue_random_nums(105);
        drain_all();

        gap_pct = 35;
        stall_pct = 35;
        queue_random_nums(105);
        drain_all();

        repeat (100) @(posedge i_clk);
        if (text_expect_q.size() != 0) begin
            $error("%0d characters never arrived", text_expect_q.size());
            err_cnt++;
        end
        $display("numbers sent: %0d signed, %0d unsigned, %0d hex, %0d spare format",
                 n_per_fmt[0], n_per_fmt[1], n_per_fmt[2], n_per_fmt[3]);
        $display("characters checked: %0d, mismatches: %0d", n_chars, err_cnt);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout waiting for the formatter");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/iaf_pkg.sv
src/iaf_front.sv
src/iaf_queue.sv
src/iaf_back.sv
src/integer_to_ascii_formatter_top.sv
dv/tb_top.sv
